// ===== src/nmcs_pkg.sv =====
// Shared types and constants of the nearest mean color selector.
package nmcs_pkg;

  // Fixed field widths
  localparam int PIX_W     = 8;
  localparam int CH_W      = 16;
  localparam int ENTRY_W   = 3 * CH_W;
  localparam int IDX_IN_W  = 9;
  localparam int IDX_OUT_W = 9;
  localparam int EIU_W     = 10;
  localparam int BP_W      = 13;
  localparam int DIST_W    = 34;
  localparam int SQ_W      = 2 * CH_W;

  // Mean arithmetic
  localparam int MEAN_FRAC_BITS = 8;
  localparam int SUM_W          = 20;
  localparam int MEAN_W         = 8 + MEAN_FRAC_BITS;
  localparam int DVD_W          = SUM_W + MEAN_FRAC_BITS;
  localparam int DCNT_W         = $clog2(DVD_W);

  // Stream packing
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;

  // Item kinds carried in tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Register map
  localparam int  CFG_ADDR_W = 3;
  localparam int  CFG_DATA_W = 32;
  localparam logic REG_EIU   = 1'b0;
  localparam logic REG_BP    = 1'b1;
  localparam logic [EIU_W-1:0] EIU_RESET = 10'd436;
  localparam logic [BP_W-1:0]  BP_RESET  = 13'd100;

  // Control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  // Per-block controls broadcast to the channel cells
  typedef struct packed {
    logic pix_en;
    logic blk_end;
    logic div_step;
  } ctl_t;

  // Item handed from cell to cell during a scan
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic [ENTRY_W-1:0] entry;
    logic [DIST_W-1:0]  dsq;
  } tok_t;

endpackage

// ===== src/nmcs_chan_cell.sv =====
// One channel cell: running sum, serial mean divider, squared-distance stage.
module nmcs_chan_cell
  import nmcs_pkg::*;
#(
  parameter int CH = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_t             ctl,
  input  logic [PIX_W-1:0] pixel,
  input  logic [BP_W-1:0]  divisor,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [DVD_W-1:0]  dq_r;
  logic [BP_W-1:0]   rem_r;
  logic [BP_W:0]     rem_sh;
  logic              q_bit;
  logic [MEAN_W-1:0] mean;
  logic [CH_W-1:0]   ent;
  logic [CH_W-1:0]   diff;
  logic [SQ_W-1:0]   sq;
  tok_t              tok_r;

  assign sum_nxt = sum_r + SUM_W'(pixel);

  // Accumulate pixels, clear after the block ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.blk_end) begin
      sum_r <= '0;
    end else if (ctl.pix_en) begin
      sum_r <= sum_nxt;
    end
  end

  // Restoring division, one quotient bit per step
  assign rem_sh = {rem_r, dq_r[DVD_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (ctl.blk_end) begin
      dq_r  <= {sum_nxt, {MEAN_FRAC_BITS{1'b0}}};
      rem_r <= '0;
    end else if (ctl.div_step) begin
      dq_r  <= {dq_r[DVD_W-2:0], q_bit};
      rem_r <= q_bit ? BP_W'(rem_sh - {1'b0, divisor}) : rem_sh[BP_W-1:0];
    end
  end

  // Saturate the quotient to the fixed-point range
  assign mean = (|dq_r[DVD_W-1:MEAN_W]) ? {MEAN_W{1'b1}} : dq_r[MEAN_W-1:0];

  // Squared difference of this channel
  assign ent  = tok_i.entry[CH*CH_W +: CH_W];
  assign diff = (ent > mean) ? (ent - mean) : (mean - ent);
  assign sq   = diff * diff;

  // Hand the partial distance to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_i.valid;
    end
    tok_r.first <= tok_i.first;
    tok_r.last  <= tok_i.last;
    tok_r.entry <= tok_i.entry;
    tok_r.dsq   <= tok_i.dsq + DIST_W'(sq);
  end

  assign tok_o = tok_r;

endmodule

// ===== src/nmcs_best_cell.sv =====
// End cell of the chain: keeps the nearest entry seen so far.
module nmcs_best_cell
  import nmcs_pkg::*;
#(
  parameter int AW = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tok_t              tok_i,
  output logic [AW-1:0]     best_idx,
  output logic [DIST_W-1:0] best_dist,
  output logic              done
);

  logic [AW-1:0]     cnt_r;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     best_idx_r;
  logic [DIST_W-1:0] best_dist_r;
  logic              done_r;
  logic              take;

  // Index of the arriving item; the first one restarts the count
  assign idx  = tok_i.first ? '0 : cnt_r;
  assign take = tok_i.valid && (tok_i.first || (tok_i.dsq < best_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= tok_i.valid && tok_i.last;
      if (tok_i.valid) begin
        cnt_r <= idx + AW'(1);
      end
    end
  end

  // Strict less-than keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r  <= idx;
      best_dist_r <= tok_i.dsq;
    end
  end

  assign best_idx  = best_idx_r;
  assign best_dist = best_dist_r;
  assign done      = done_r;

endmodule

// ===== src/nearest_mean_color_selector_unit.sv =====
// Steps: a load item or a non-final pixel item is taken while idle; a final pixel
// item starts the serial mean divide, then a scan that reads one searched entry per cycle,
// then passes through the three channel cells, the best cell, the drain state and the output register.
// No new item is taken from a block end until its result is loaded into the output register.
// Reset: rst_n synchronous, clears sums, control and registers (436, 100);
// the color table is not cleared and must be written before it is searched.
module nearest_mean_color_selector_unit
  import nmcs_pkg::*;
#(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // entry_index, mean_red, mean_green, mean_blue, pixel_red, pixel_green,
  // pixel_blue, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic [0:0]            in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // best_index, best_distance_sq, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Input field slices
  logic [IDX_IN_W-1:0] f_idx;
  logic [ENTRY_W-1:0]  f_entry;
  logic [PIX_W-1:0]    f_pix [3];

  assign f_idx    = in_tdata[8:0];
  assign f_entry  = in_tdata[56:9];
  assign f_pix[0] = in_tdata[64:57];
  assign f_pix[1] = in_tdata[72:65];
  assign f_pix[2] = in_tdata[80:73];

  // Configuration registers
  logic [EIU_W-1:0] eiu_r;
  logic [BP_W-1:0]  bp_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eiu_r <= EIU_RESET;
      bp_r  <= BP_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_EIU: eiu_r <= cfg_pwdata[EIU_W-1:0];
        REG_BP:  bp_r  <= cfg_pwdata[BP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_EIU: cfg_prdata = CFG_DATA_W'(eiu_r);
      REG_BP:  cfg_prdata = CFG_DATA_W'(bp_r);
      default: cfg_prdata = '0;
    endcase
  end

  // Sequencer
  state_t state_r, state_nxt;
  logic   in_fire;
  logic   pix_fire;
  logic   blk_end;
  logic   div_step;
  logic   scan_rd;
  logic   scan_last;
  logic   div_last;
  logic   out_load;
  logic   best_done;
  logic   out_tvalid_r;

  logic [DCNT_W-1:0] div_cnt_r;
  logic [CW-1:0]     scan_cnt_r;
  logic [CW-1:0]     lim_r;
  logic [BP_W-1:0]   div_r;
  logic [31:0]       lim_w;

  assign in_fire   = in_tvalid && in_tready;
  assign pix_fire  = in_fire && (in_tuser[0] == OP_PIXEL);
  assign blk_end   = pix_fire && in_tlast;
  assign div_last  = (div_cnt_r == DCNT_W'(DVD_W - 1));
  assign scan_last = (scan_cnt_r == (lim_r - CW'(1)));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (blk_end) state_nxt = S_DIV;
      S_DIV:   if (div_last) state_nxt = S_SCAN;
      S_SCAN:  if (scan_last) state_nxt = S_DRAIN;
      S_DRAIN: if (best_done) state_nxt = S_DONE;
      S_DONE:  if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_step  = 1'b0;
    scan_rd   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_DIV:   div_step  = 1'b1;
      S_SCAN:  scan_rd   = 1'b1;
      S_DRAIN: ;
      S_DONE:  out_load  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Search limit: at least one entry, at most the table depth
  always_comb begin
    lim_w = (eiu_r == '0) ? 32'd1 : 32'(eiu_r);
    if (lim_w > 32'(TABLE_DEPTH)) begin
      lim_w = 32'(TABLE_DEPTH);
    end
  end

  // Capture block parameters and step the counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r  <= '0;
      scan_cnt_r <= '0;
      lim_r      <= CW'(1);
      div_r      <= BP_W'(1);
    end else begin
      if (blk_end) begin
        div_cnt_r  <= '0;
        scan_cnt_r <= '0;
        lim_r      <= CW'(lim_w);
        div_r      <= (bp_r == '0) ? BP_W'(1) : bp_r;
      end else begin
        if (div_step) div_cnt_r <= div_cnt_r + DCNT_W'(1);
        if (scan_rd)  scan_cnt_r <= scan_cnt_r + CW'(1);
      end
    end
  end

  // Color table: one write port for loads, one registered read for the scan
  logic [ENTRY_W-1:0] table_mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rdata_r;
  logic               tbl_wr;

  assign tbl_wr = in_fire && (in_tuser[0] == OP_LOAD) &&
                  (32'(f_idx) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      table_mem[AW'(f_idx)] <= f_entry;
    end
    if (scan_rd) begin
      rdata_r <= table_mem[scan_cnt_r[AW-1:0]];
    end
  end

  // Mark read data entering the chain
  logic rd_v_r, rd_first_r, rd_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r <= (scan_cnt_r == '0);
    rd_last_r  <= scan_last;
  end

  // Chain of channel cells
  ctl_t ctl;
  tok_t tok [4];

  assign ctl.pix_en   = pix_fire;
  assign ctl.blk_end  = blk_end;
  assign ctl.div_step = div_step;

  assign tok[0].valid = rd_v_r;
  assign tok[0].first = rd_first_r;
  assign tok[0].last  = rd_last_r;
  assign tok[0].entry = rdata_r;
  assign tok[0].dsq   = '0;

  for (genvar c = 0; c < 3; c++) begin : g_cell
    nmcs_chan_cell #(
      .CH(c)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .pixel  (f_pix[c]),
      .divisor(div_r),
      .tok_i  (tok[c]),
      .tok_o  (tok[c+1])
    );
  end

  logic [AW-1:0]     best_idx;
  logic [DIST_W-1:0] best_dist;

  nmcs_best_cell #(
    .AW(AW)
  ) u_best (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok_i    (tok[3]),
    .best_idx (best_idx),
    .best_dist(best_dist),
    .done     (best_done)
  );

  // Output register
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [DIST_W-1:0]    out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= IDX_OUT_W'(best_idx);
      out_dist_r <= best_dist;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W - IDX_OUT_W - DIST_W){1'b0}}, out_dist_r, out_idx_r};

  // Checks
  a_blk_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    blk_end |=> state_r == S_DIV)
    else $error("block end did not start the divider");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_rd |-> scan_cnt_r < lim_r)
    else $error("scan address past the search limit");

  a_done_drain: assert property (@(posedge clk) disable iff (!rst_n)
    best_done |-> state_r == S_DRAIN)
    else $error("scan finished outside drain");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_tvalid_r || out_tready))
    else $error("result overwrote a pending item");

endmodule

// ===== test/tb_nearest_mean_color_selector_unit.sv =====
// Self-checking stream testbench for the nearest mean color selector unit.
module tb_nearest_mean_color_selector_unit;
  import nmcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 512;
  localparam longint unsigned MEAN_MAX = (64'd1 << MEAN_W) - 64'd1;

  // One input item, unpacked into its fields
  typedef struct packed {
    logic              op;
    logic [IDX_IN_W-1:0] idx;
    logic [CH_W-1:0]   mr;
    logic [CH_W-1:0]   mg;
    logic [CH_W-1:0]   mb;
    logic [PIX_W-1:0]  pr;
    logic [PIX_W-1:0]  pg;
    logic [PIX_W-1:0]  pb;
    logic              last;
  } item_t;

  // One search result
  typedef struct packed {
    logic [IDX_OUT_W-1:0] idx;
    logic [DIST_W-1:0]    dsq;
  } match_t;

  typedef enum logic {
    ROW_REG,
    ROW_ITEM
  } row_kind_e;

  // Directed stimulus row: a register write or an item, with an optional fixed answer
  typedef struct packed {
    row_kind_e        kind;
    logic             reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    item_t            it;
    logic             typed;
    match_t           fixed;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Shadow of the block state
  logic [CH_W-1:0]  mean_tbl [DEPTH][3];
  logic [SUM_W-1:0] ch_sum [3];
  logic [EIU_W-1:0] eiu_reg;
  logic [BP_W-1:0]  bp_reg;

  match_t   pending_matches [$];
  dir_row_t dir_rows [$];
  int       errors = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;

  nearest_mean_color_selector_unit #(
    .TABLE_DEPTH (DEPTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Advance the shadow state by one item; return 1 with the nearest entry on a block end
  function automatic bit nearest_after_item(input item_t it, output match_t m);
    longint unsigned mu [3];
    longint unsigned a, diff, d, best_d;
    int unsigned     cnt, div, best_i;
    m = '0;
    if (it.op == OP_LOAD) begin
      mean_tbl[it.idx][0] = it.mr;
      mean_tbl[it.idx][1] = it.mg;
      mean_tbl[it.idx][2] = it.mb;
      return 1'b0;
    end
    ch_sum[0] = ch_sum[0] + SUM_W'(it.pr);
    ch_sum[1] = ch_sum[1] + SUM_W'(it.pg);
    ch_sum[2] = ch_sum[2] + SUM_W'(it.pb);
    if (!it.last) return 1'b0;
    div = (bp_reg == '0) ? 1 : int'(bp_reg);
    for (int c = 0; c < 3; c++) begin
      mu[c] = (64'(ch_sum[c]) << MEAN_FRAC_BITS) / 64'(div);
      if (mu[c] > MEAN_MAX) mu[c] = MEAN_MAX;
    end
    // Zero searches entry 0 alone, anything above the depth searches them all
    cnt = (eiu_reg == '0) ? 1 : int'(eiu_reg);
    if (cnt > DEPTH) cnt = DEPTH;
    best_d = 0;
    best_i = 0;
    for (int unsigned i = 0; i < cnt; i++) begin
      d = 0;
      for (int c = 0; c < 3; c++) begin
        a = 64'(mean_tbl[i][c]);
        diff = (a > mu[c]) ? a - mu[c] : mu[c] - a;
        d += diff * diff;
      end
      // Strict compare keeps the lowest index on a tie
      if (i == 0 || d < best_d) begin
        best_d = d;
        best_i = i;
      end
    end
    ch_sum[0] = '0;
    ch_sum[1] = '0;
    ch_sum[2] = '0;
    m.idx = IDX_OUT_W'(best_i);
    m.dsq = DIST_W'(best_d);
    return 1'b1;
  endfunction

  // Pixel channel value, with the extremes drawn often
  function automatic logic [PIX_W-1:0] rand_pix();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic item_t rand_load();
    item_t it;
    it.op = OP_LOAD;
    it.idx = IDX_IN_W'($urandom);
    it.mr = CH_W'($urandom);
    it.mg = CH_W'($urandom);
    it.mb = CH_W'($urandom);
    it.pr = PIX_W'($urandom);
    it.pg = PIX_W'($urandom);
    it.pb = PIX_W'($urandom);
    it.last = 1'($urandom);
    return it;
  endfunction

  function automatic item_t rand_pixel(input logic last);
    item_t it;
    it = rand_load();
    it.op = OP_PIXEL;
    it.pr = rand_pix();
    it.pg = rand_pix();
    it.pb = rand_pix();
    it.last = last;
    return it;
  endfunction

  function automatic dir_row_t reg_row(input logic sel, input logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  function automatic dir_row_t load_row(input logic [IDX_IN_W-1:0] idx,
                                        input logic [CH_W-1:0] r, g, b, input logic last);
    dir_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.it = rand_load();
    row.it.idx = idx;
    row.it.mr = r;
    row.it.mg = g;
    row.it.mb = b;
    row.it.last = last;
    return row;
  endfunction

  function automatic dir_row_t pix_row(input logic [PIX_W-1:0] r, g, b, input logic last,
                                       input logic typed, input logic [IDX_OUT_W-1:0] eidx,
                                       input logic [DIST_W-1:0] edist);
    dir_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.it = rand_pixel(last);
    row.it.pr = r;
    row.it.pg = g;
    row.it.pb = b;
    row.typed = typed;
    row.fixed.idx = eidx;
    row.fixed.dsq = edist;
    return row;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input dir_row_t row);
    dir_rows = {dir_rows, row};
  endfunction

  // Offer one item, hold it until accepted, then update the shadow state
  task automatic send_item(input item_t it, input logic typed, input match_t fixed);
    match_t m;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, it.pb, it.pg, it.pr, it.mb, it.mg, it.mr, it.idx};
    in_tuser <= it.op;
    in_tlast <= it.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (nearest_after_item(it, m)) begin
      if (typed) m = fixed;
      pending_matches = {pending_matches, m};
    end
  endtask

  // Drop valid and wait until every search has reported and the pipe is empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write a register, then read it back
  task automatic set_reg(input logic sel, input logic [CFG_DATA_W-1:0] val);
    logic [CFG_DATA_W-1:0] want;
    want = (sel == REG_EIU) ? CFG_DATA_W'(val[EIU_W-1:0]) : CFG_DATA_W'(val[BP_W-1:0]);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {sel, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (sel == REG_EIU) eiu_reg = val[EIU_W-1:0];
    else bp_reg = val[BP_W-1:0];
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want) begin
      $error("register %0d: expected %0d, got %0d", sel, want, cfg_prdata);
      errors++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Mostly whole blocks of the configured size, some of random size, loads mixed in
  task automatic run_blocks(input int n_items);
    int sent, len, eff;
    sent = 0;
    while (sent < n_items) begin
      eff = (bp_reg == '0) ? 1 : int'(bp_reg);
      if ($urandom_range(99) < 80 && eff <= 16) len = eff;
      else len = $urandom_range(1, 16);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(99) < 15) begin
          send_item(rand_load(), 1'b0, '0);
          sent++;
        end
        send_item(rand_pixel(k == len - 1), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Randomize the ready side and check each result against the oldest prediction
  always @(posedge clk) begin : result_check
    match_t want;
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_matches.size() == 0) begin
        $error("unexpected result: best_index %0d best_distance_sq %0d",
               out_tdata[8:0], out_tdata[42:9]);
        errors++;
      end else begin
        want = pending_matches.pop_front();
        if (out_tdata[8:0] !== want.idx) begin
          $error("best_index: expected %0d, got %0d", want.idx, out_tdata[8:0]);
          errors++;
        end
        if (out_tdata[42:9] !== want.dsq) begin
          $error("best_distance_sq: expected %0d, got %0d", want.dsq, out_tdata[42:9]);
          errors++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("tb_nearest_mean_color_selector_unit: done, errors");
    $finish;
  end

  initial begin
    int   waited;
    item_t it;
    for (int c = 0; c < 3; c++) ch_sum[c] = '0;
    eiu_reg = EIU_RESET;
    bp_reg = BP_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every table entry so no search reads an unwritten one
    for (int i = 0; i < DEPTH; i++) begin
      it = rand_load();
      it.idx = IDX_IN_W'(i);
      send_item(it, 1'b0, '0);
    end

    // Directed: single entry, extremes, saturated mean, zero count, ties, zero divisor
    add_row(reg_row(REG_EIU, 32'd1));
    add_row(reg_row(REG_BP, 32'd1));
    add_row(load_row(9'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    add_row(pix_row(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 9'd0, 34'd0));
    add_row(load_row(9'd0, 16'hffff, 16'hffff, 16'hffff, 1'b0));
    add_row(pix_row(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 9'd0, 34'd12884508675));
    add_row(pix_row(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 9'd0, 34'd195075));
    add_row(pix_row(8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 9'd0, 34'd0));
    add_row(pix_row(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 9'd0, 34'd0));
    add_row(reg_row(REG_EIU, 32'd0));
    add_row(pix_row(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 9'd0, 34'd12884508675));
    add_row(load_row(9'd1, 16'hffff, 16'hffff, 16'hffff, 1'b1));
    add_row(reg_row(REG_EIU, 32'd2));
    add_row(pix_row(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 9'd0, 34'd195075));
    add_row(load_row(9'd1, 16'hff00, 16'hff00, 16'hff00, 1'b0));
    add_row(pix_row(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 9'd1, 34'd0));
    add_row(reg_row(REG_BP, 32'd0));
    add_row(pix_row(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 9'd1, 34'd0));
    add_row(load_row(9'd511, 16'h0000, 16'hffff, 16'h0000, 1'b0));
    add_row(reg_row(REG_EIU, 32'd1023));
    add_row(reg_row(REG_BP, 32'd8191));
    add_row(pix_row(8'd12, 8'd200, 8'd3, 1'b0, 1'b0, 9'd0, 34'd0));
    add_row(load_row(9'd5, 16'h1234, 16'h8000, 16'h00ff, 1'b1));
    add_row(pix_row(8'd255, 8'd0, 8'd128, 1'b1, 1'b0, 9'd0, 34'd0));
    add_row(reg_row(REG_EIU, 32'd512));
    add_row(reg_row(REG_BP, 32'd4096));
    add_row(pix_row(8'd0, 8'd255, 8'd0, 1'b1, 1'b0, 9'd0, 34'd0));
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_REG) begin
        wait_idle();
        set_reg(dir_rows[r].reg_sel, dir_rows[r].reg_val);
      end else begin
        send_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].fixed);
      end
    end

    // Random phases, each with its own setting and idle pattern
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          set_reg(REG_EIU, (32'($urandom) << EIU_W) | 32'($urandom_range(1, 512)));
          set_reg(REG_BP, (32'($urandom) << BP_W) | 32'($urandom_range(1, 8)));
        end
        1: begin
          send_idle_pct = 77;
          stall_pct = 0;
          set_reg(REG_EIU, 32'd1);
          set_reg(REG_BP, 32'd0);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 77;
          set_reg(REG_EIU, (32'($urandom) << EIU_W) | 32'($urandom_range(513, 1023)));
          set_reg(REG_BP, 32'($urandom_range(1, 16)));
        end
        default: begin
          send_idle_pct = 25;
          stall_pct = 25;
          set_reg(REG_EIU, 32'($urandom_range(0, 1023)));
          set_reg(REG_BP, 32'd8191);
        end
      endcase
      run_blocks(20);
    end

    // Drain the remaining results, then allow a full search worth of cycles
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_matches.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (600) @(posedge clk);
    if (pending_matches.size() != 0) begin
      $error("%0d expected results never arrived", pending_matches.size());
      errors++;
    end
    if (errors == 0) $display("tb_nearest_mean_color_selector_unit: done, clean");
    else $display("tb_nearest_mean_color_selector_unit: done, errors");
    $finish;
  end

endmodule
